[src/mmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_pkg: shared types for the multichannel moving median filter
// Word formats on the ports, the per-channel ring pointer record and the
// command that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package mmm_pkg;

    // width of ring position and fill count (window length is at most 15)
    localparam int POS_W = 4;

    // input word: sample tagged with its sensor channel
    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] sample;
    } t_in_word;

    // result word: median of the channel window
    typedef struct packed {
        logic [2:0]  out_channel;
        logic [15:0] median;
    } t_out_word;

    // per-channel ring pointer record
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] fill;
    } t_meta;

    // classified command for the back part
    typedef struct packed {
        logic             present;
        logic [2:0]       channel;
        logic [15:0]      sample;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] fill;
    } t_cmd;

endpackage
`default_nettype wire

[src/mmm_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_fifo: two-entry queue
// Decouples producer and consumer; push/full on one side, pop/empty on the
// other, head word always shown on the read port.
// ----------------------------------------------------------------------------
module mmm_fifo #(
    parameter type t_data = logic
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_data i_data,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_data      o_data
);

    t_data      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // occupancy update
    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[src/mmm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_front: word intake and classification
// Takes a word, looks up the channel ring pointers, advances them and issues
// a command carrying write position and fill count to the back part.
// ----------------------------------------------------------------------------
module mmm_front #(
    parameter int NUM_CHANNELS  = 8,
    parameter int WINDOW_LENGTH = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire mmm_pkg::t_in_word i_data,
    output logic                   o_cmd_push,
    input  wire logic              i_cmd_full,
    output mmm_pkg::t_cmd          o_cmd
);
    import mmm_pkg::*;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [POS_W-1:0] WL     = POS_W'(WINDOW_LENGTH);
    localparam logic [POS_W-1:0] WL_END = POS_W'(WINDOW_LENGTH - 1);

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_ISSUE = 2'b10
    } t_front_state;

    t_front_state          r_state;
    t_in_word              r_word;
    logic                  r_present;
    logic                  r_meta_hit;
    t_meta                 r_meta_rd;
    t_meta                 r_meta_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_meta_vld;

    logic                  accept;
    logic                  in_present;
    logic [CH_IDX_W-1:0]   in_idx;
    logic [CH_IDX_W-1:0]   cur_idx;
    logic [POS_W-1:0]      pos_cur;
    logic [POS_W-1:0]      fill_cur;
    t_meta                 meta_new;
    logic                  issue;

    assign o_full     = (r_state != F_IDLE);
    assign accept     = i_push && (r_state == F_IDLE);
    assign in_present = (32'(i_data.channel) < NUM_CHANNELS);
    assign in_idx     = CH_IDX_W'(i_data.channel);
    assign cur_idx    = CH_IDX_W'(r_word.channel);
    assign issue      = (r_state == F_ISSUE) && !i_cmd_full;

    // advance ring position and fill count
    always_comb begin
        pos_cur  = r_meta_hit ? r_meta_rd.pos  : '0;
        fill_cur = r_meta_hit ? r_meta_rd.fill : '0;
        meta_new.pos  = (pos_cur >= WL_END) ? '0 : pos_cur + POS_W'(1);
        meta_new.fill = (fill_cur >= WL) ? WL : fill_cur + POS_W'(1);
    end

    // command to the back part
    always_comb begin
        o_cmd.present = r_present;
        o_cmd.channel = r_word.channel;
        o_cmd.sample  = r_word.sample;
        o_cmd.pos     = pos_cur;
        o_cmd.fill    = meta_new.fill;
    end
    assign o_cmd_push = issue;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_meta_vld <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_ISSUE;
                    end
                end
                F_ISSUE: begin
                    if (issue) begin
                        r_state <= F_IDLE;
                        if (r_present) begin
                            r_meta_vld[cur_idx] <= 1'b1;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // word capture and pointer memory lookup
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word    <= i_data;
            r_present <= in_present;
            if (in_present) begin
                r_meta_rd  <= r_meta_mem[in_idx];
                r_meta_hit <= r_meta_vld[in_idx];
            end else begin
                r_meta_hit <= 1'b0;
            end
        end
    end

    // pointer memory write-back
    always_ff @(posedge i_clk) begin
        if (issue && r_present) begin
            r_meta_mem[cur_idx] <= meta_new;
        end
    end

endmodule
`default_nettype wire

[src/mmm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_back: window store and median sort
// Writes the sample to window memory, reads the channel window into lanes, sorts
// it with odd-even transposition passes and emits the median (absent: zero).
// ----------------------------------------------------------------------------
module mmm_back #(
    parameter int NUM_CHANNELS  = 8,
    parameter int WINDOW_LENGTH = 5,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire mmm_pkg::t_cmd i_cmd,
    output logic               o_out_push,
    input  wire logic          i_out_full,
    output mmm_pkg::t_out_word o_out
);
    import mmm_pkg::*;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DEPTH    = NUM_CHANNELS * WINDOW_LENGTH;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MID      = WINDOW_LENGTH / 2;
    localparam logic [POS_W-1:0] WL     = POS_W'(WINDOW_LENGTH);
    localparam logic [POS_W-1:0] WL_END = POS_W'(WINDOW_LENGTH - 1);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_WRITE = 5'b00010,
        B_READ  = 5'b00100,
        B_SORT  = 5'b01000,
        B_DONE  = 5'b10000
    } t_back_state;

    t_back_state            r_state;
    t_cmd                   r_cmd;
    logic [ADDR_W-1:0]      r_base;
    logic [POS_W-1:0]       r_k;
    logic [POS_W-1:0]       r_cap_k;
    logic                   r_rd_vld;
    logic [POS_W-1:0]       r_pass;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SAMPLE_BITS-1:0] r_win_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_lane [WINDOW_LENGTH];
    logic [SAMPLE_BITS-1:0] n_sort [WINDOW_LENGTH];

    logic                   start;
    logic                   issue_rd;
    logic                   last_cap;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      head_base;

    assign start     = (r_state == B_IDLE) && !i_cmd_empty;
    assign o_cmd_pop = start;
    assign issue_rd  = (r_state == B_READ) && (r_k < WL);
    assign last_cap  = r_rd_vld && (r_cap_k == WL_END);
    assign wr_en     = (r_state == B_WRITE);
    assign wr_addr   = r_base + ADDR_W'(r_cmd.pos);
    assign rd_addr   = r_base + ADDR_W'(r_k);
    assign head_base = ADDR_W'(CH_IDX_W'(i_cmd.channel)) * ADDR_W'(WINDOW_LENGTH);

    // one odd-even transposition pass over the lanes
    always_comb begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            n_sort[i] = r_lane[i];
        end
        for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
            if ((i % 2) == int'(r_pass[0]) && (r_lane[i+1] < r_lane[i])) begin
                n_sort[i]   = r_lane[i+1];
                n_sort[i+1] = r_lane[i];
            end
        end
    end

    // result word
    always_comb begin
        o_out.out_channel = r_cmd.channel;
        o_out.median      = r_cmd.present ? 16'(r_lane[MID]) : 16'd0;
    end
    assign o_out_push = (r_state == B_DONE) && !i_out_full;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue_rd;
            case (r_state)
                B_IDLE: begin
                    if (start) begin
                        r_state <= i_cmd.present ? B_WRITE : B_DONE;
                    end
                end
                B_WRITE: r_state <= B_READ;
                B_READ: begin
                    if (last_cap) begin
                        r_state <= B_SORT;
                    end
                end
                B_SORT: begin
                    if (r_pass >= WL_END) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (!i_out_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // command latch, counters and lanes
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd  <= i_cmd;
            r_base <= head_base;
        end
        if (wr_en) begin
            r_k <= '0;
        end else if (issue_rd) begin
            r_k <= r_k + POS_W'(1);
        end
        r_cap_k <= r_k;
        if (last_cap) begin
            r_pass <= '0;
        end else if (r_state == B_SORT) begin
            r_pass <= r_pass + POS_W'(1);
        end
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            if (r_rd_vld && (r_cap_k == POS_W'(i))) begin
                // entries never written since reset read as zero
                r_lane[i] <= (POS_W'(i) < r_cmd.fill) ? r_rd_data : '0;
            end else if (r_state == B_SORT) begin
                r_lane[i] <= n_sort[i];
            end
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_win_mem[wr_addr] <= SAMPLE_BITS'(r_cmd.sample);
        end
        if (issue_rd) begin
            r_rd_data <= r_win_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[src/multichannel_moving_median.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput is set by the back part: one window memory read per cycle, then one
// sort pass per cycle; it takes no new command until its result is pushed.
// The front takes a new word only after issuing the command for the last one;
// a two-entry queue sits between the parts.
// Reset (synchronous, active low) empties both queues and marks every channel
// ring unwritten, so all windows read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multichannel_moving_median: per-channel five-sample moving median
// Stores each sample in its channel ring and returns the ring median.
// ----------------------------------------------------------------------------
module multichannel_moving_median #(
    parameter int NUM_CHANNELS  = 8,
    parameter int WINDOW_LENGTH = 5,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire mmm_pkg::t_in_word  i_data,
    output logic                    empty,
    input  wire logic               pop,
    output mmm_pkg::t_out_word      o_data
);
    import mmm_pkg::*;

    t_cmd      fe_cmd;
    logic      fe_cmd_push;
    logic      q_cmd_full;
    logic      q_cmd_empty;
    t_cmd      q_cmd;
    logic      be_cmd_pop;
    logic      be_out_push;
    logic      q_out_full;
    t_out_word be_out;

    // front: intake and classification
    mmm_front #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_data     (i_data),
        .o_cmd_push (fe_cmd_push),
        .i_cmd_full (q_cmd_full),
        .o_cmd      (fe_cmd)
    );

    // command queue
    mmm_fifo #(
        .t_data (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_cmd_push),
        .o_full  (q_cmd_full),
        .i_data  (fe_cmd),
        .i_pop   (be_cmd_pop),
        .o_empty (q_cmd_empty),
        .o_data  (q_cmd)
    );

    // back: window store and sort
    mmm_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_cmd_empty),
        .o_cmd_pop   (be_cmd_pop),
        .i_cmd       (q_cmd),
        .o_out_push  (be_out_push),
        .i_out_full  (q_out_full),
        .o_out       (be_out)
    );

    // result queue
    mmm_fifo #(
        .t_data (t_out_word)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_out_push),
        .o_full  (q_out_full),
        .i_data  (be_out),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

[src/mmm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_checker: port-level checks for the moving median filter
// Watches the top-level ports and flags reset, intake and result slips.
// ----------------------------------------------------------------------------
module mmm_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               push,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire mmm_pkg::t_out_word o_data
);

    // reset leaves no result waiting and the intake open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("not idle after reset");

    // an accepted word closes the intake for its lookup cycle
    a_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("intake open right after accept");

    // a waiting result stays put until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_data))
        else $error("waiting result changed");

    // a channel beyond the configured count reports a zero median
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (32'(o_data.out_channel) >= NUM_CHANNELS) |-> o_data.median == 16'd0)
        else $error("absent channel with nonzero median");

endmodule

bind multichannel_moving_median mmm_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);
`default_nettype wire

[tb/tb_multichannel_moving_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_moving_median: self-checking bench for the moving median
// Pushes channel-tagged samples, keeps its own copy of every channel ring,
// predicts each window median and checks popped words in order, with random
// stalls on both sides, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_multichannel_moving_median;
    import mmm_pkg::*;

    localparam int NUM_CH      = 8;
    localparam int WIN_LEN     = 5;
    localparam int N_RANDOM    = 1030;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int STEADY_LO   = 450;
    localparam int STEADY_HI   = 650;
    localparam int IDLE_PCT    = 11;
    localparam int SETTLE_AT   = 700;
    localparam int MAX_LINES   = 40;

    // pending word plus a flag that makes the sender wait for a full drain
    typedef struct packed {
        logic     settle;
        t_in_word word;
    } t_pending;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_data  = '0;
    logic      full;
    logic      empty;
    t_out_word o_data;

    t_pending    sample_q[$];
    t_out_word   median_q[$];
    logic [15:0] ring_mem [NUM_CH][WIN_LEN];
    int unsigned ring_pos [NUM_CH];

    int   n_items    = 0;
    int   n_accepted = 0;
    int   n_errors   = 0;
    int   cycles     = 0;
    int   hold_left  = 0;
    bit   hold_done  = 1'b0;
    logic steady;

    multichannel_moving_median dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    always #2 i_clk = ~i_clk;

    // no idling on either side in the middle of the run
    assign steady = (n_accepted >= STEADY_LO) && (n_accepted < STEADY_HI);

    task automatic report_mismatch(input string msg);
        // print only the first few, keep counting all
        if (n_errors < MAX_LINES) $display("mismatch @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // store sample in its ring, advance position, queue the window median
    task automatic predict_median(input t_in_word w);
        logic [15:0] srt [WIN_LEN];
        logic [15:0] t;
        t_out_word   r;
        int unsigned p;
        int          i;
        int          j;
        r.out_channel = w.channel;
        r.median      = '0;
        if (w.channel < NUM_CH) begin
            p = ring_pos[w.channel];
            if (p >= WIN_LEN) p = 0;
            ring_mem[w.channel][p] = w.sample;
            p++;
            if (p >= WIN_LEN) p = 0;
            ring_pos[w.channel] = p;
            for (i = 0; i < WIN_LEN; i++) srt[i] = ring_mem[w.channel][i];
            for (i = 0; i < WIN_LEN - 1; i++) begin
                for (j = i + 1; j < WIN_LEN; j++) begin
                    if (srt[j] < srt[i]) begin
                        t      = srt[i];
                        srt[i] = srt[j];
                        srt[j] = t;
                    end
                end
            end
            r.median = srt[WIN_LEN / 2];
        end
        median_q.push_back(r);
    endtask

    task automatic add_item(input logic [2:0] ch, input logic [15:0] smp, input bit settle);
        t_pending e;
        e.settle       = settle;
        e.word.channel = ch;
        e.word.sample  = smp;
        sample_q.push_back(e);
        n_items++;
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sender: offers the next pending word, holds it while full
    always @(posedge i_clk) begin : driver
        bit offer;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_median(i_data);
                n_accepted++;
            end
            if (!push || !full) begin
                offer = 1'b0;
                if (sample_q.size() != 0
                    && !(sample_q[0].settle && median_q.size() != 0)
                    && (steady || $urandom_range(99) >= IDLE_PCT))
                    offer = 1'b1;
                if (offer) begin
                    i_data <= sample_q[0].word;
                    void'(sample_q.pop_front());
                end
                push <= offer;
            end
        end
    end

    // receiver: checks popped words, random stalls and one long hold-off
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        bit        take;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (median_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word ch %0d median %0d",
                                              o_data.out_channel, o_data.median));
                end else begin
                    want = median_q.pop_front();
                    if (o_data.out_channel !== want.out_channel)
                        report_mismatch($sformatf("out_channel %0d, want %0d",
                                                  o_data.out_channel, want.out_channel));
                    if (o_data.median !== want.median)
                        report_mismatch($sformatf("ch %0d median %0d, want %0d",
                                                  want.out_channel, o_data.median,
                                                  want.median));
                end
            end
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                take = 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                take = 1'b0;
            end else begin
                take = steady || ($urandom_range(99) >= IDLE_PCT);
            end
            pop <= take;
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        int          c;
        int          k;
        int          mode;
        logic [2:0]  ch;
        logic [15:0] smp;
        for (c = 0; c < NUM_CH; c++) begin
            ring_pos[c] = 0;
            for (k = 0; k < WIN_LEN; k++) ring_mem[c][k] = '0;
        end

        // directed: extremes, early zero-filled windows, ring wrap, no-echo zeros
        add_item(3'd0, 16'hFFFF, 1'b0);
        add_item(3'd0, 16'hFFFF, 1'b0);
        add_item(3'd0, 16'hFFFF, 1'b0);
        add_item(3'd0, 16'h0000, 1'b0);
        add_item(3'd0, 16'h0001, 1'b0);
        add_item(3'd0, 16'h1234, 1'b0);
        add_item(3'd7, 16'h0001, 1'b0);
        add_item(3'd7, 16'hFFFF, 1'b0);
        add_item(3'd7, 16'h0000, 1'b0);
        add_item(3'd7, 16'h8000, 1'b0);
        add_item(3'd7, 16'h7FFF, 1'b0);
        add_item(3'd7, 16'hAAAA, 1'b0);
        add_item(3'd7, 16'h5555, 1'b0);
        add_item(3'd3, 16'h0000, 1'b0);
        add_item(3'd3, 16'h0000, 1'b0);
        add_item(3'd1, 16'h0001, 1'b0);
        add_item(3'd2, 16'h0002, 1'b0);
        add_item(3'd4, 16'h0100, 1'b0);
        add_item(3'd5, 16'h1000, 1'b0);
        add_item(3'd6, 16'hFFFE, 1'b0);

        // random: bursts on one channel, ties, extremes and small steps
        ch  = 3'd0;
        smp = '0;
        for (k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(9) >= 4) ch = 3'($urandom_range(NUM_CH - 1));
            mode = $urandom_range(9);
            case (mode)
                5, 6:    smp = 16'($urandom_range(3));
                7:       smp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                8:       smp = 16'(smp + 16'($urandom_range(15)));
                9:       smp = '0;
                default: smp = 16'($urandom_range(65535));
            endcase
            add_item(ch, smp, (k == 0) || (k == SETTLE_AT));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || median_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
